### design/icfg_pkg.sv
`default_nettype none

package icfg_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_INFO = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNSUP = 1'b1;

    localparam logic [4:0] OP_ENABLE      = 5'd0;
    localparam logic [4:0] OP_ERASE       = 5'd1;
    localparam logic [4:0] OP_RD_PROG     = 5'd2;
    localparam logic [4:0] OP_WR_PROG     = 5'd3;
    localparam logic [4:0] OP_RD_DATA     = 5'd4;
    localparam logic [4:0] OP_WR_DATA     = 5'd5;
    localparam logic [4:0] OP_SIGNATURE   = 5'd6;
    localparam logic [4:0] OP_WR_LOCK     = 5'd7;
    localparam logic [4:0] OP_RD_LOCK     = 5'd8;
    localparam logic [4:0] OP_WR_FUSE     = 5'd9;
    localparam logic [4:0] OP_RD_FUSE     = 5'd10;
    localparam logic [4:0] OP_WR_PROG_PG  = 5'd11;
    localparam logic [4:0] OP_RD_PROG_PG  = 5'd12;
    localparam logic [4:0] OP_WR_DATA_PG  = 5'd13;
    localparam logic [4:0] OP_RD_DATA_PG  = 5'd14;
    localparam logic [4:0] OP_PAGE_TX     = 5'd15;
    localparam logic [4:0] OP_PAGE_RX     = 5'd16;
    localparam logic [4:0] OP_DECODE_LOCK = 5'd17;
    localparam logic [4:0] OP_DECODE_FUSE = 5'd18;

    localparam logic [1:0] MODEL_LEGACY = 2'd0;
    localparam logic [1:0] MODEL_8253   = 2'd1;
    localparam logic [1:0] MODEL_S5X    = 2'd2;

    localparam logic [1:0] REG_LEGACY_MODE = 2'd0;
    localparam logic [1:0] REG_DEVICE_MODEL = 2'd1;
    localparam logic [1:0] REG_PAGE_LOG2   = 2'd2;

    localparam logic [3:0] RST_PAGE_LOG2 = 4'd6;
    localparam logic [3:0] MAX_PAGE_LOG2 = 4'd8;

    localparam logic [7:0] CMD_PREFIX     = 8'hAC;
    localparam logic [7:0] CMD_ENABLE     = 8'h53;
    localparam logic [7:0] CMD_ERASE_NEW  = 8'h80;
    localparam logic [7:0] CMD_ERASE_OLD  = 8'h04;
    localparam logic [7:0] CMD_RD_PROG    = 8'h20;
    localparam logic [7:0] CMD_WR_PROG    = 8'h40;
    localparam logic [7:0] CMD_RD_DATA    = 8'hA0;
    localparam logic [7:0] CMD_WR_DATA    = 8'hC0;
    localparam logic [7:0] CMD_SIGNATURE  = 8'h28;
    localparam logic [7:0] CMD_RD_LOCK    = 8'h24;
    localparam logic [7:0] CMD_RD_FUSE    = 8'h21;
    localparam logic [7:0] CMD_WR_FUSE    = 8'h10;
    localparam logic [7:0] CMD_LOCK_NEW   = 8'hE0;
    localparam logic [7:0] CMD_LOCK_OLD   = 8'h07;
    localparam logic [7:0] CMD_WR_PROG_PG = 8'h50;
    localparam logic [7:0] CMD_RD_PROG_PG = 8'h30;
    localparam logic [7:0] CMD_WR_DATA_PG = 8'hD0;
    localparam logic [7:0] CMD_RD_DATA_PG = 8'hB0;
    localparam logic [7:0] OLD_RD_PROG    = 8'h01;
    localparam logic [7:0] OLD_WR_PROG    = 8'h02;
    localparam logic [7:0] OLD_RD_DATA    = 8'h05;
    localparam logic [7:0] OLD_WR_DATA    = 8'h06;
    localparam logic [7:0] MASK_HI_BITS   = 8'hF8;
    localparam logic [7:0] MASK_A13       = 8'h04;
    localparam logic [7:0] MASK_LOCK3     = 8'h07;
    localparam logic [7:0] MASK_FUSE4     = 8'h0F;
    localparam logic [7:0] MASK_LOCK_S5X  = 8'h1C;

    typedef struct packed {
        logic       legacy_mode;
        logic [1:0] device_model;
        logic [3:0] page_log2;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       status;
    } t_item;

    typedef struct packed {
        t_item [3:0] items;
        logic [1:0]  last_idx;
    } t_frame;

    function automatic t_item mk_item(logic [1:0] kind, logic [7:0] value, logic status);
        t_item it;
        it.kind   = kind;
        it.value  = value;
        it.status = status;
        return it;
    endfunction

endpackage

`default_nettype wire

### design/icfg_front.sv
`default_nettype none

module icfg_front #(
    parameter int ADDR_BITS = 16
) (
    input  wire icfg_pkg::t_cfg   i_cfg,
    input  wire logic [4:0]       i_opcode,
    input  wire logic [15:0]      i_address,
    input  wire logic [7:0]       i_operand_byte,
    output icfg_pkg::t_frame      o_frame
);
    import icfg_pkg::*;

    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

    logic [15:0] addr;
    logic [15:0] paddr;
    logic [3:0]  lg;
    logic [7:0]  d_inv;
    logic [7:0]  hi_bits;
    logic [7:0]  a13;
    logic [7:0]  code;
    logic        old;
    logic        wr;
    t_item       tx0;
    t_item       rx_slot;
    t_item       unsup;

    assign addr    = i_address & ADDR_MASK;
    assign lg      = (i_cfg.page_log2 > MAX_PAGE_LOG2) ? MAX_PAGE_LOG2 : i_cfg.page_log2;
    assign paddr   = addr & (16'hFFFF << lg);
    assign d_inv   = ~i_operand_byte;
    assign hi_bits = {addr[12:8], 3'b000} & MASK_HI_BITS;
    assign a13     = addr[13] ? MASK_A13 : 8'h00;
    assign old     = i_cfg.legacy_mode;
    assign wr      = i_opcode[0];
    assign tx0     = mk_item(KIND_TX, 8'h00, STATUS_OK);
    assign rx_slot = mk_item(KIND_RX, 8'h00, STATUS_OK);
    assign unsup   = mk_item(KIND_INFO, 8'h00, STATUS_UNSUP);

    always_comb begin
        code = 8'h00;
        o_frame.items    = {4{tx0}};
        o_frame.last_idx = 2'd0;
        o_frame.items[0] = unsup;
        case (i_opcode)
            OP_ENABLE: begin
                o_frame.items[0] = mk_item(KIND_TX, CMD_PREFIX, STATUS_OK);
                o_frame.items[1] = mk_item(KIND_TX, CMD_ENABLE, STATUS_OK);
                o_frame.last_idx = old ? 2'd2 : 2'd3;
            end
            OP_ERASE: begin
                o_frame.items[0] = mk_item(KIND_TX, CMD_PREFIX, STATUS_OK);
                o_frame.items[1] = mk_item(KIND_TX, old ? CMD_ERASE_OLD : CMD_ERASE_NEW,
                                           STATUS_OK);
                o_frame.last_idx = old ? 2'd2 : 2'd3;
            end
            OP_RD_PROG, OP_WR_PROG, OP_RD_DATA, OP_WR_DATA: begin
                if (old) begin
                    case (i_opcode)
                        OP_RD_PROG: code = OLD_RD_PROG | a13;
                        OP_WR_PROG: code = OLD_WR_PROG | a13;
                        OP_RD_DATA: code = OLD_RD_DATA;
                        default:    code = OLD_WR_DATA;
                    endcase
                    o_frame.items[0] = mk_item(KIND_TX, code | hi_bits, STATUS_OK);
                    o_frame.items[1] = mk_item(KIND_TX, addr[7:0], STATUS_OK);
                    o_frame.items[2] = wr ? mk_item(KIND_TX, i_operand_byte, STATUS_OK)
                                          : rx_slot;
                    o_frame.last_idx = 2'd2;
                end else begin
                    case (i_opcode)
                        OP_RD_PROG: code = CMD_RD_PROG;
                        OP_WR_PROG: code = CMD_WR_PROG;
                        OP_RD_DATA: code = CMD_RD_DATA;
                        default:    code = CMD_WR_DATA;
                    endcase
                    o_frame.items[0] = mk_item(KIND_TX, code, STATUS_OK);
                    o_frame.items[1] = mk_item(KIND_TX, addr[15:8], STATUS_OK);
                    o_frame.items[2] = mk_item(KIND_TX, addr[7:0], STATUS_OK);
                    o_frame.items[3] = wr ? mk_item(KIND_TX, i_operand_byte, STATUS_OK)
                                          : rx_slot;
                    o_frame.last_idx = 2'd3;
                end
            end
            OP_SIGNATURE: begin
                o_frame.items[0] = mk_item(KIND_TX, CMD_SIGNATURE, STATUS_OK);
                o_frame.items[1] = mk_item(KIND_TX, addr[15:8], STATUS_OK);
                o_frame.items[2] = mk_item(KIND_TX, addr[7:0], STATUS_OK);
                o_frame.items[3] = rx_slot;
                o_frame.last_idx = 2'd3;
            end
            OP_WR_LOCK: begin
                if (i_cfg.device_model != MODEL_S5X) begin
                    o_frame.items[0] = mk_item(KIND_TX, CMD_PREFIX, STATUS_OK);
                    o_frame.items[1] = (i_cfg.device_model == MODEL_8253)
                        ? mk_item(KIND_TX, CMD_LOCK_NEW | (d_inv & MASK_LOCK3), STATUS_OK)
                        : mk_item(KIND_TX, CMD_LOCK_OLD | d_inv, STATUS_OK);
                    o_frame.last_idx = old ? 2'd2 : 2'd3;
                end
            end
            OP_RD_LOCK: begin
                if (i_cfg.device_model == MODEL_8253 || i_cfg.device_model == MODEL_S5X) begin
                    o_frame.items[0] = mk_item(KIND_TX, CMD_RD_LOCK, STATUS_OK);
                    o_frame.items[1] = tx0;
                    o_frame.items[3] = rx_slot;
                    o_frame.last_idx = 2'd3;
                end
            end
            OP_WR_FUSE: begin
                if (i_cfg.device_model == MODEL_8253) begin
                    o_frame.items[0] = mk_item(KIND_TX, CMD_PREFIX, STATUS_OK);
                    o_frame.items[1] = mk_item(KIND_TX, CMD_WR_FUSE | (d_inv & MASK_FUSE4),
                                               STATUS_OK);
                    o_frame.last_idx = 2'd3;
                end
            end
            OP_RD_FUSE: begin
                if (i_cfg.device_model == MODEL_8253) begin
                    o_frame.items[0] = mk_item(KIND_TX, CMD_RD_FUSE, STATUS_OK);
                    o_frame.items[3] = rx_slot;
                    o_frame.last_idx = 2'd3;
                end
            end
            OP_WR_PROG_PG, OP_RD_PROG_PG, OP_WR_DATA_PG, OP_RD_DATA_PG: begin
                case (i_opcode)
                    OP_WR_PROG_PG: code = CMD_WR_PROG_PG;
                    OP_RD_PROG_PG: code = CMD_RD_PROG_PG;
                    OP_WR_DATA_PG: code = CMD_WR_DATA_PG;
                    default:       code = CMD_RD_DATA_PG;
                endcase
                o_frame.items[0] = mk_item(KIND_TX, code, STATUS_OK);
                o_frame.items[1] = mk_item(KIND_TX, paddr[15:8], STATUS_OK);
                o_frame.items[2] = mk_item(KIND_TX, paddr[7:0], STATUS_OK);
                o_frame.last_idx = 2'd2;
            end
            OP_PAGE_TX: begin
                o_frame.items[0] = mk_item(KIND_TX, i_operand_byte, STATUS_OK);
            end
            OP_PAGE_RX: begin
                o_frame.items[0] = rx_slot;
            end
            OP_DECODE_LOCK: begin
                if (i_cfg.device_model == MODEL_8253) begin
                    o_frame.items[0] = mk_item(KIND_INFO, d_inv & MASK_LOCK3, STATUS_OK);
                end else if (i_cfg.device_model == MODEL_S5X) begin
                    o_frame.items[0] = mk_item(KIND_INFO, i_operand_byte & MASK_LOCK_S5X,
                                               STATUS_OK);
                end
            end
            OP_DECODE_FUSE: begin
                if (i_cfg.device_model == MODEL_8253) begin
                    o_frame.items[0] = mk_item(KIND_INFO, d_inv & MASK_FUSE4, STATUS_OK);
                end
            end
            default: begin
                o_frame.items[0] = unsup;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/icfg_queue.sv
`default_nettype none

module icfg_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire icfg_pkg::t_frame i_frame,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_head_valid,
    output icfg_pkg::t_frame      o_head
);
    import icfg_pkg::*;

    t_frame                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full       = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### design/icfg_back.sv
`default_nettype none

module icfg_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire icfg_pkg::t_frame i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_byte_value,
    output logic                  o_status,
    output logic                  o_last
);
    import icfg_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_item      r_item;
    logic       r_last;
    logic       load;
    logic       at_last;

    assign load    = i_head_valid && (!r_out_valid || i_out_ready);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = at_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_head.items[r_idx];
            r_last <= at_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_item.kind;
    assign o_byte_value = r_item.value;
    assign o_status     = r_item.status;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### design/isp_command_frame_generator_top.sv
// An accepted transaction is written into the frame queue and each entry
// then into the output register. One result per cycle while i_out_ready is
// high; an operation yields 1 to 4 entries, emitted one entry per cycle.
// A two-entry frame queue lets input keep flowing while results drain.
// Reset (synchronous, active low) empties the queue and output, and loads
// legacy_mode=1, device_model=0, page_size_log2=6.
`default_nettype none

module isp_command_frame_generator_top #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [4:0]  i_opcode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_operand_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic             o_status,
    output logic             o_last
);
    import icfg_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    t_frame     frame;
    t_frame     head;
    logic       full;
    logic       head_valid;
    logic       pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.legacy_mode  <= 1'b1;
            r_cfg.device_model <= MODEL_LEGACY;
            r_cfg.page_log2    <= RST_PAGE_LOG2;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LEGACY_MODE:  r_cfg.legacy_mode  <= pwdata[0];
                REG_DEVICE_MODEL: r_cfg.device_model <= pwdata[1:0];
                REG_PAGE_LOG2:    r_cfg.page_log2    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEGACY_MODE:  prdata = {31'd0, r_cfg.legacy_mode};
            REG_DEVICE_MODEL: prdata = {30'd0, r_cfg.device_model};
            REG_PAGE_LOG2:    prdata = {28'd0, r_cfg.page_log2};
            default:          prdata = 32'd0;
        endcase
    end

    icfg_front #(
        .ADDR_BITS(ADDR_BITS)
    ) u_front (
        .i_cfg          (r_cfg),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_operand_byte (i_operand_byte),
        .o_frame        (frame)
    );

    assign o_in_ready = !full;

    icfg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid),
        .i_frame      (frame),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    icfg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
